>>> hw/rtl/length_prefixed_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL files.
`ifndef LENGTH_PREFIXED_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising edge of clk while rst_n is high.
`define LPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpd assertion failed");
// Check prop on every rising edge of clk, reset included.
`define LPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lpd assertion failed");
`else
`define LPD_ASSERT(label, clk, rst_n, prop)
`define LPD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hw/rtl/lpd_pkg.sv
// Types, constants and the route function of the length-prefixed deframer.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int unsigned SIZE_LIMIT_W = 17;
    localparam int unsigned ID_W         = 32;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned REMAIN_W     = 17;
    localparam int unsigned HDR_CNT_W    = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 32;

    localparam logic [SIZE_LIMIT_W-1:0] SIZE_LIMIT_RST    = 17'd65536;
    localparam logic [ID_W-1:0]         GATE_ID_LIMIT_RST = 32'd1999;
    localparam logic [ID_W-1:0]         GAME_ID_LOW_RST   = 32'd2000;
    localparam logic [ID_W-1:0]         GAME_ID_LIMIT_RST = 32'd2999;

    // Header byte 7 is the last one; code 8 and up is the body phase.
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = 4'd7;
    localparam logic [HDR_CNT_W-1:0] HDR_BODY = 4'd8;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ROUTE_GATE    = 2'd0,
        ROUTE_GAME    = 2'd1,
        ROUTE_INVALID = 2'd2
    } t_route;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_LIMIT    = 2'd0,
        CFG_GATE_ID_LIMIT = 2'd1,
        CFG_GAME_ID_LOW   = 2'd2,
        CFG_GAME_ID_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SIZE_LIMIT_W-1:0] size_limit;
        logic [ID_W-1:0]         gate_id_limit;
        logic [ID_W-1:0]         game_id_low;
        logic [ID_W-1:0]         game_id_limit;
    } t_cfg;

    typedef struct packed {
        t_kind           kind;
        t_route          route;
        logic [ID_W-1:0] message_id;
        logic [LEN_W-1:0] body_length;
        logic [7:0]      data_byte;
        logic            frame_end;
    } t_result;

    // Gate test first, then the game window; anything else is flagged.
    function automatic t_route pick_route(input logic [ID_W-1:0] id, input t_cfg cfg);
        t_route r;
        if (id < cfg.gate_id_limit) begin
            r = ROUTE_GATE;
        end else if (id >= cfg.game_id_low && id < cfg.game_id_limit) begin
            r = ROUTE_GAME;
        end else begin
            r = ROUTE_INVALID;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/lpd_cfg.sv
// Configuration register file of the deframer.
`timescale 1ns / 1ps

module lpd_cfg import lpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SIZE_LIMIT:    n_cfg.size_limit    = i_cfg_data[SIZE_LIMIT_W-1:0];
                CFG_GATE_ID_LIMIT: n_cfg.gate_id_limit = i_cfg_data;
                CFG_GAME_ID_LOW:   n_cfg.game_id_low   = i_cfg_data;
                CFG_GAME_ID_LIMIT: n_cfg.game_id_limit = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_limit    <= SIZE_LIMIT_RST;
            r_cfg.gate_id_limit <= GATE_ID_LIMIT_RST;
            r_cfg.game_id_low   <= GAME_ID_LOW_RST;
            r_cfg.game_id_limit <= GAME_ID_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> hw/rtl/lpd_parser.sv
// Input register and frame parsing state of the deframer.
`timescale 1ns / 1ps

`include "length_prefixed_deframer_top_macros.svh"

module lpd_parser import lpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_res_ready,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic [HDR_CNT_W-1:0] r_hdr_count, n_hdr_count;
    logic [LEN_W-1:0]     r_length, n_length;
    logic [ID_W-1:0]      r_id, n_id;
    logic [REMAIN_W-1:0]  r_remain, n_remain;
    t_route               r_route, n_route;
    logic                 r_closed, n_closed;

    logic    advance;
    logic    res_valid;
    t_result res;

    // Advance the held byte once the result side can take whatever it makes.
    assign advance     = r_in_valid & i_res_ready;
    assign o_in_ready  = ~r_in_valid | i_res_ready;
    assign o_res_valid = advance & res_valid;
    assign o_res       = res;

    always_comb begin
        n_hdr_count = r_hdr_count;
        n_length    = r_length;
        n_id        = r_id;
        n_remain    = r_remain;
        n_route     = r_route;
        n_closed    = r_closed;
        res_valid   = 1'b0;
        res.kind        = KIND_HEADER;
        res.route       = r_route;
        res.message_id  = r_id;
        res.body_length = r_length;
        res.data_byte   = 8'd0;
        res.frame_end   = 1'b0;

        if (r_closed) begin
            // drop every byte until reset
            n_closed = 1'b1;
        end else if (!r_hdr_count[HDR_CNT_W-1]) begin
            // header: bytes 0..3 are the length, 4..7 the id, little endian
            if (!r_hdr_count[2]) begin
                n_length[{r_hdr_count[1:0], 3'b000} +: 8] = r_in_byte;
            end else begin
                n_id[{r_hdr_count[1:0], 3'b000} +: 8] = r_in_byte;
            end
            n_hdr_count = r_hdr_count + 4'd1;
            if (r_hdr_count == HDR_LAST) begin
                res_valid       = 1'b1;
                res.route       = pick_route(n_id, i_cfg);
                n_route         = res.route;
                res.message_id  = n_id;
                res.body_length = n_length;
                if (n_length >= {{(LEN_W-SIZE_LIMIT_W){1'b0}}, i_cfg.size_limit}) begin
                    n_closed = 1'b1;
                    res.kind = KIND_ERROR;
                end else if (n_length == '0) begin
                    n_hdr_count   = '0;
                    n_remain      = '0;
                    res.frame_end = 1'b1;
                end else begin
                    n_remain = n_length[REMAIN_W-1:0];
                end
            end
        end else if (r_remain == '0) begin
            // body phase with nothing left: restart a header with this byte
            n_length    = {{(LEN_W-8){1'b0}}, r_in_byte};
            n_hdr_count = 4'd1;
        end else begin
            n_remain      = r_remain - 17'd1;
            res_valid     = 1'b1;
            res.kind      = KIND_BODY;
            res.data_byte = r_in_byte;
            res.frame_end = (r_remain == 17'd1);
            if (r_remain == 17'd1) begin
                n_hdr_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_hdr_count <= '0;
            r_length    <= '0;
            r_id        <= '0;
            r_remain    <= '0;
            r_route     <= ROUTE_GATE;
            r_closed    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_hdr_count <= n_hdr_count;
                r_length    <= n_length;
                r_id        <= n_id;
                r_remain    <= n_remain;
                r_route     <= n_route;
                r_closed    <= n_closed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    `LPD_ASSERT(a_closed_sticks, i_clk, i_rst_n, r_closed |=> r_closed)
    `LPD_ASSERT(a_hdr_count_range, i_clk, i_rst_n, r_hdr_count <= HDR_BODY)
    `LPD_ASSERT(a_body_has_bytes, i_clk, i_rst_n, (!r_closed && r_hdr_count == HDR_BODY) |-> (r_remain != '0))
    `LPD_ASSERT(a_error_closes, i_clk, i_rst_n,
        (o_res_valid && o_res.kind == KIND_ERROR) |=> r_closed)

endmodule

>>> hw/rtl/lpd_out_stage.sv
// Output register of the deframer, packing results onto the master stream.
`timescale 1ns / 1ps

`include "length_prefixed_deframer_top_macros.svh"

module lpd_out_stage import lpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    output logic        o_res_ready,
    input  t_result     i_res,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready   = ~r_valid | m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_res.data_byte, r_res.body_length, r_res.message_id};
    assign m_axis_tuser  = {r_res.route, r_res.kind};
    assign m_axis_tlast  = r_res.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    `LPD_ASSERT(a_no_push_when_full, i_clk, i_rst_n, i_res_valid |-> o_res_ready)
    `LPD_ASSERT(a_held_kind_valid, i_clk, i_rst_n, r_valid |-> (r_res.kind != 2'd3))
    `LPD_ASSERT(a_error_has_no_end, i_clk, i_rst_n,
        (r_valid && r_res.kind == KIND_ERROR) |-> !r_res.frame_end)

endmodule

>>> hw/rtl/length_prefixed_deframer_top.sv
// Throughput is one stream byte per clock while the consumer keeps up: a byte sits in the input
// register while the header/body counter and the id and length compares settle,
// and the resulting transaction lands in the output register, which drives the
// output stream. Each frame is an 8-byte header
// (32-bit little-endian body length, then 32-bit little-endian message id)
// followed by the body; the eighth header byte yields a header transaction with
// the route, each body byte yields a body transaction, the last one with tlast.
// A length at or above size_limit yields an error transaction and all later
// bytes are dropped until reset. Input and output readiness are tied through the
// two registers only: a stalled consumer leaves one result in the output register
// and one byte in the input register before s_axis_tready drops, and header bytes
// also wait for room at the output even though they yield nothing. Configuration
// writes are taken every cycle and belong to idle periods.
`timescale 1ns / 1ps

module length_prefixed_deframer_top import lpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] stream_byte
    // stream output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,   // [31:0] message_id, [63:32] body_length,
                                                  // [71:64] data_byte
    output logic [3:0]            m_axis_tuser,   // [1:0] kind, [3:2] route
    output logic                  m_axis_tlast,   // frame_end
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    lpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpd_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .o_res_ready   (res_ready),
        .i_res         (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> verif/length_prefixed_deframer_top_tb.sv
// Self-checking testbench for the length-prefixed deframer top level.
`timescale 1ns / 1ps

module length_prefixed_deframer_top_tb import lpd_pkg::*; ();

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_kind       kind;
        t_route      route;
        logic [31:0] message_id;
        logic [31:0] body_length;
        logic [7:0]  data_byte;
        logic        frame_end;
    } frame_event_t;

    typedef struct {
        logic [31:0] body_length;
        logic [31:0] message_id;
        logic [7:0]  fill;
        bit          typed;
        t_kind       kind;
        t_route      route;
        logic        frame_end;
    } frame_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;
    logic [3:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow configuration and deframing state.
    logic [16:0] lim_size = SIZE_LIMIT_RST;
    logic [31:0] lim_gate = GATE_ID_LIMIT_RST;
    logic [31:0] game_lo  = GAME_ID_LOW_RST;
    logic [31:0] game_hi  = GAME_ID_LIMIT_RST;
    logic [3:0]  hdr_seen = '0;
    logic [31:0] len_acc  = '0;
    logic [31:0] id_acc   = '0;
    logic [16:0] remain   = '0;
    t_route      cur_route = ROUTE_GATE;
    logic        stream_closed = 1'b0;

    frame_event_t pending_events[$];
    int mismatches = 0;
    int bytes_sent = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    // Default configuration: gate below 1999, game window [2000, 2999).
    frame_row_t opening_frames [9] = '{
        '{32'd0,   32'd0,          8'h00, 1'b1, KIND_HEADER, ROUTE_GATE,    1'b1},
        '{32'd1,   32'd1998,       8'hFF, 1'b1, KIND_HEADER, ROUTE_GATE,    1'b0},
        '{32'd2,   32'd1999,       8'hFF, 1'b1, KIND_HEADER, ROUTE_INVALID, 1'b0},
        '{32'd0,   32'd2000,       8'h00, 1'b1, KIND_HEADER, ROUTE_GAME,    1'b1},
        '{32'd3,   32'd2998,       8'h80, 1'b1, KIND_HEADER, ROUTE_GAME,    1'b0},
        '{32'd0,   32'd2999,       8'h00, 1'b1, KIND_HEADER, ROUTE_INVALID, 1'b1},
        '{32'd1,   32'hFFFF_FFFF,  8'h7F, 1'b1, KIND_HEADER, ROUTE_INVALID, 1'b0},
        '{32'd5,   32'h1234_5678,  8'h01, 1'b0, KIND_HEADER, ROUTE_GATE,    1'b0},
        '{32'd257, 32'hA5C3_0F96,  8'h10, 1'b0, KIND_HEADER, ROUTE_GATE,    1'b0}
    };

    // Size limit 1, gate below 2^32-1, empty game window.
    frame_row_t closing_frames [3] = '{
        '{32'd0, 32'd5,         8'h00, 1'b1, KIND_HEADER, ROUTE_GATE,    1'b1},
        '{32'd0, 32'hFFFF_FFFF, 8'h00, 1'b1, KIND_HEADER, ROUTE_INVALID, 1'b1},
        '{32'd1, 32'hFFFF_FFFE, 8'h3C, 1'b1, KIND_ERROR,  ROUTE_GATE,    1'b0}
    };

    length_prefixed_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Advance the shadow deframer by one accepted byte and queue what it yields.
    task automatic deframe_byte(input logic [7:0] b);
        int pos;
        logic last;
        if (stream_closed) return;
        if (hdr_seen < HDR_BODY) begin
            pos = int'(hdr_seen[1:0]);
            if (hdr_seen < 4'd4) len_acc[8*pos +: 8] = b;
            else id_acc[8*pos +: 8] = b;
            hdr_seen++;
            if (hdr_seen < HDR_BODY) return;
            if (id_acc < lim_gate) cur_route = ROUTE_GATE;
            else if (id_acc >= game_lo && id_acc < game_hi) cur_route = ROUTE_GAME;
            else cur_route = ROUTE_INVALID;
            if (len_acc >= {15'd0, lim_size}) begin
                stream_closed = 1'b1;
                pending_events.push_back('{KIND_ERROR, cur_route, id_acc, len_acc, 8'd0, 1'b0});
            end else if (len_acc == '0) begin
                hdr_seen = '0;
                remain = '0;
                pending_events.push_back('{KIND_HEADER, cur_route, id_acc, len_acc, 8'd0, 1'b1});
            end else begin
                remain = len_acc[16:0];
                pending_events.push_back('{KIND_HEADER, cur_route, id_acc, len_acc, 8'd0, 1'b0});
            end
            return;
        end
        // Body phase with nothing left: restart the header on this byte.
        if (remain == '0) begin
            len_acc = {24'd0, b};
            hdr_seen = 4'd1;
            return;
        end
        remain--;
        last = (remain == '0);
        pending_events.push_back('{KIND_BODY, cur_route, id_acc, len_acc, b, last});
        if (last) hdr_seen = '0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_frame(input frame_row_t row, input bit random_body);
        int k;
        for (k = 0; k < 4; k++) send_byte(row.body_length[8*k +: 8]);
        for (k = 0; k < 4; k++) send_byte(row.message_id[8*k +: 8]);
        // Hold the header result to the values written in the table.
        if (row.typed && pending_events.size() > 0) begin
            pending_events[pending_events.size()-1].kind = row.kind;
            pending_events[pending_events.size()-1].route = row.route;
            pending_events[pending_events.size()-1].frame_end = row.frame_end;
        end
        for (k = 0; k < int'(row.body_length); k++)
            send_byte(random_body ? 8'($urandom) : row.fill + 8'(k));
    endtask

    task automatic send_random_frames(input int target, input int max_len);
        frame_row_t row;
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            row.typed = 1'b0;
            row.fill = '0;
            if ($urandom_range(0, 3) == 0) row.body_length = $urandom_range(0, max_len);
            else row.body_length = $urandom_range(0, (max_len < 6) ? max_len : 6);
            case ($urandom_range(0, 11))
                0:       row.message_id = lim_gate - 1;
                1:       row.message_id = lim_gate;
                2:       row.message_id = game_lo - 1;
                3:       row.message_id = game_lo;
                4:       row.message_id = game_hi - 1;
                5:       row.message_id = game_hi;
                6:       row.message_id = '0;
                7:       row.message_id = '1;
                default: row.message_id = $urandom;
            endcase
            send_frame(row, 1'b1);
        end
    endtask

    task automatic wait_results_done();
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // Drop valid, let every result drain, then cover the pipeline depth.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SIZE_LIMIT:    lim_size = val[16:0];
            CFG_GATE_ID_LIMIT: lim_gate = val;
            CFG_GAME_ID_LOW:   game_lo = val;
            CFG_GAME_ID_LIMIT: game_hi = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
    endtask

    // Receiver: random backpressure, or a counted hold-off when requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        frame_event_t want;
        frame_event_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = frame_event_t'({m_axis_tuser[1:0], m_axis_tuser[3:2], m_axis_tdata[31:0],
                                  m_axis_tdata[63:32], m_axis_tdata[71:64], m_axis_tlast});
            if (pending_events.size() == 0) begin
                log_mismatch($sformatf("unexpected transaction kind=%0d id=%h len=%h data=%h",
                                       got.kind, got.message_id, got.body_length,
                                       got.data_byte));
            end else begin
                want = pending_events.pop_front();
                if (got !== want)
                    log_mismatch($sformatf(
                        "want k%0d r%0d id=%h len=%h d=%h e%b, got k%0d r%0d id=%h len=%h d=%h e%b",
                        want.kind, want.route, want.message_id, want.body_length,
                        want.data_byte, want.frame_end, got.kind, got.route, got.message_id,
                        got.body_length, got.data_byte, got.frame_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 82;
        foreach (opening_frames[i]) send_frame(opening_frames[i], 1'b0);
        settle();

        write_reg(CFG_SIZE_LIMIT, 32'd64);
        write_reg(CFG_GATE_ID_LIMIT, 32'd100);
        write_reg(CFG_GAME_ID_LOW, 32'd150);
        write_reg(CFG_GAME_ID_LIMIT, 32'd300);
        send_random_frames(250, 63);
        // Pause the source until the output side has caught up.
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_results_done();
        send_random_frames(250, 63);
        settle();

        send_idle_pct = 82;
        recv_idle_pct = 36;
        write_reg(CFG_SIZE_LIMIT, 32'd65536);
        write_reg(CFG_GATE_ID_LIMIT, 32'd0);
        write_reg(CFG_GAME_ID_LOW, 32'd0);
        write_reg(CFG_GAME_ID_LIMIT, 32'hFFFF_FFFF);
        send_random_frames(200, 40);
        // Stall the output for a long stretch while bytes keep coming.
        hold_cycles = 300;
        send_random_frames(300, 40);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_SIZE_LIMIT, 32'd17);
        write_reg(CFG_GATE_ID_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_GAME_ID_LOW, 32'hFFFF_FFFF);
        write_reg(CFG_GAME_ID_LIMIT, 32'd0);
        send_random_frames(450, 16);
        settle();

        // Oversize closes the stream for good, so it comes last.
        write_reg(CFG_SIZE_LIMIT, 32'd1);
        foreach (closing_frames[i]) send_frame(closing_frames[i], 1'b0);
        repeat (12) send_byte(8'($urandom));
        settle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        if (pending_events.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_events.size()));
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_cfg.sv
hw/rtl/lpd_parser.sv
hw/rtl/lpd_out_stage.sv
hw/rtl/length_prefixed_deframer_top.sv
verif/length_prefixed_deframer_top_tb.sv
